// ===== hw/rtl/zbpr_pkg.sv =====
package zbpr_pkg;

   localparam int COLS_DEF = 218;
   localparam int ROWS_DEF = 50;

   // controller state codes, also the datapath operation
   localparam logic [3:0] OP_CLEAR = 4'd0;
   localparam logic [3:0] OP_IDLE  = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIVC  = 4'd3;
   localparam logic [3:0] OP_DIVR  = 4'd4;
   localparam logic [3:0] OP_ROT   = 4'd5;
   localparam logic [3:0] OP_ADDR  = 4'd6;
   localparam logic [3:0] OP_MRD   = 4'd7;
   localparam logic [3:0] OP_MWR   = 4'd8;
   localparam logic [3:0] OP_DONE  = 4'd9;

   localparam logic [2:0] CSR_YAW_COS   = 3'd0;
   localparam logic [2:0] CSR_YAW_SIN   = 3'd1;
   localparam logic [2:0] CSR_ROLL_COS  = 3'd2;
   localparam logic [2:0] CSR_ROLL_SIN  = 3'd3;
   localparam logic [2:0] CSR_PITCH_COS = 3'd4;
   localparam logic [2:0] CSR_PITCH_SIN = 3'd5;
   localparam logic [2:0] CSR_VIEW_DIST = 3'd6;
   localparam logic [2:0] CSR_DEPTH_OFS = 3'd7;

   localparam logic [5:0] MUL_LAST  = 6'd4;
   localparam logic [5:0] DIV_LAST  = 6'd35;
   localparam logic [5:0] PHASE_LAST = 6'd4;
   localparam logic [2:0] STAGE_LAST = 3'd5;

   typedef struct packed {
      logic       load;
      logic [3:0] op;
      logic [5:0] cnt;
      logic [2:0] stage;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

   function automatic logic [7:0] shade_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h2E;
         4'd1:    c = 8'h2C;
         4'd2:    c = 8'h2D;
         4'd3:    c = 8'h7E;
         4'd4:    c = 8'h3A;
         4'd5:    c = 8'h3B;
         4'd6:    c = 8'h3D;
         4'd7:    c = 8'h21;
         4'd8:    c = 8'h2A;
         4'd9:    c = 8'h23;
         4'd10:   c = 8'h24;
         4'd11:   c = 8'h40;
         default: c = 8'h40;
      endcase
      return c;
   endfunction

   // positions clamp to the full 16-bit range, normals to +-1.0
   function automatic logic [15:0] sat_rot(input logic signed [20:0] r, input logic pos);
      logic signed [20:0] lo;
      logic signed [20:0] hi;
      logic signed [20:0] v;
      lo = pos ? -21'sd32768 : -21'sd16384;
      hi = pos ? 21'sd32767 : 21'sd16384;
      v  = (r < lo) ? lo : ((r > hi) ? hi : r);
      return v[15:0];
   endfunction

endpackage

// ===== hw/rtl/zbpr_ctrl.sv =====
module zbpr_ctrl
   import zbpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tuser,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] stage_ff, stage_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_load;

   assign accept   = (state_ff == OP_IDLE) && req_tvalid;
   assign out_load = (state_ff == OP_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 6'd1;
      stage_in = stage_ff;
      case (state_ff)
         OP_CLEAR: begin
            if (sts.clear_done) state_in = OP_IDLE;
         end
         OP_IDLE: begin
            cnt_in   = '0;
            stage_in = '0;
            if (req_tvalid) state_in = req_tuser ? OP_ADDR : OP_MUL;
         end
         OP_MUL: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = OP_DIVC;
               cnt_in   = '0;
            end
         end
         OP_DIVC: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = OP_DIVR;
               cnt_in   = '0;
            end
         end
         OP_DIVR: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = OP_ROT;
               cnt_in   = '0;
            end
         end
         OP_ROT: begin
            if (cnt_ff == PHASE_LAST) begin
               cnt_in   = '0;
               stage_in = stage_ff + 3'd1;
               if (stage_ff == STAGE_LAST) state_in = OP_ADDR;
            end
         end
         OP_ADDR: state_in = OP_MRD;
         OP_MRD:  state_in = OP_MWR;
         OP_MWR:  state_in = OP_DONE;
         OP_DONE: begin
            if (out_load) state_in = OP_IDLE;
         end
         default: state_in = OP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (out_load)   rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= OP_CLEAR;
         cnt_ff       <= '0;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready   = (state_ff == OP_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign cmd.load     = accept;
   assign cmd.op       = state_ff;
   assign cmd.cnt      = cnt_ff;
   assign cmd.stage    = stage_ff;
   assign cmd.out_load = out_load;

endmodule

// ===== hw/rtl/zbpr_dp.sv =====
module zbpr_dp
   import zbpr_pkg::*;
#(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic [111:0] req_tdata,
   input  logic         req_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  cmd_type      cmd,
   output sts_type      sts,
   output logic [103:0] rsp_tdata
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam logic [9:0]  ROWS_L = 10'(ROWS);
   localparam logic [10:0] COLS_L = 11'(COLS);
   localparam logic signed [35:0] COL_MID = 36'(COLS / 2);
   localparam logic signed [35:0] ROW_MID = 36'(ROWS / 2);

   // configuration registers
   logic signed [15:0] yaw_cos_ff, yaw_sin_ff, roll_cos_ff, roll_sin_ff;
   logic signed [15:0] pitch_cos_ff, pitch_sin_ff;
   logic [9:0]         view_dist_ff, depth_ofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_cos_ff   <= 16'sd16384;
         yaw_sin_ff   <= '0;
         roll_cos_ff  <= 16'sd16384;
         roll_sin_ff  <= '0;
         pitch_cos_ff <= 16'sd16384;
         pitch_sin_ff <= '0;
         view_dist_ff <= 10'd200;
         depth_ofs_ff <= 10'd270;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_YAW_COS:   yaw_cos_ff   <= csr_wdata;
            CSR_YAW_SIN:   yaw_sin_ff   <= csr_wdata;
            CSR_ROLL_COS:  roll_cos_ff  <= csr_wdata;
            CSR_ROLL_SIN:  roll_sin_ff  <= csr_wdata;
            CSR_PITCH_COS: pitch_cos_ff <= csr_wdata;
            CSR_PITCH_SIN: pitch_sin_ff <= csr_wdata;
            CSR_VIEW_DIST: view_dist_ff <= csr_wdata[9:0];
            CSR_DEPTH_OFS: depth_ofs_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // item registers
   logic               kind_ff;
   logic signed [15:0] v_ff [6];
   logic signed [15:0] pz0_ff;
   logic signed [19:0] den_ff;
   logic               lit_ff;
   logic [3:0]         shade_ff;
   logic [5:0]         rrow_ff;
   logic [7:0]         rcol_ff;

   logic signed [15:0] in_nz;
   logic signed [16:0] lum;
   logic [20:0]        lum11;
   logic [6:0]         shade_raw;

   assign in_nz     = req_tdata[95:80];
   assign lum       = -17'(in_nz);
   assign lum11     = 21'(lum[15:0]) * 21'd11;
   assign shade_raw = lum11[20:14];

   // arithmetic registers
   logic signed [43:0] p_ff;
   logic signed [26:0] colnum_ff;
   logic signed [33:0] rownum_ff;
   logic signed [27:0] rowden_ff;
   logic signed [33:0] acc_ff;
   logic [26:0]        rem_ff;
   logic [33:0]        quo_ff;
   logic [27:0]        dd_ff;
   logic               dneg_ff;
   logic [CW-1:0]      colidx_ff;
   logic [RW-1:0]      rowidx_ff;
   logic               col_ok_ff, row_ok_ff;

   // shared multiplier operands
   logic signed [26:0] mul_a;
   logic signed [16:0] mul_b;
   logic [2:0]         ia, ib;
   logic signed [15:0] rc, rs;
   logic               rpos;

   always_comb begin
      case (cmd.stage)
         3'd0:    begin ia = 3'd0; ib = 3'd2; rc = yaw_cos_ff;   rs = yaw_sin_ff;   end
         3'd1:    begin ia = 3'd0; ib = 3'd1; rc = roll_cos_ff;  rs = roll_sin_ff;  end
         3'd2:    begin ia = 3'd1; ib = 3'd2; rc = pitch_cos_ff; rs = pitch_sin_ff; end
         3'd3:    begin ia = 3'd3; ib = 3'd5; rc = yaw_cos_ff;   rs = yaw_sin_ff;   end
         3'd4:    begin ia = 3'd3; ib = 3'd4; rc = roll_cos_ff;  rs = roll_sin_ff;  end
         3'd5:    begin ia = 3'd4; ib = 3'd5; rc = pitch_cos_ff; rs = pitch_sin_ff; end
         default: begin ia = 3'd0; ib = 3'd2; rc = yaw_cos_ff;   rs = yaw_sin_ff;   end
      endcase
      rpos = (cmd.stage < 3'd3);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == OP_MUL) begin
         case (cmd.cnt)
            6'd0: begin mul_a = 27'(v_ff[0]); mul_b = 17'({1'b0, view_dist_ff}); end
            6'd1: begin mul_a = 27'(v_ff[1]); mul_b = 17'({1'b0, view_dist_ff}); end
            6'd2: begin mul_a = p_ff[26:0];   mul_b = 17'sd100; end
            6'd3: begin mul_a = 27'(den_ff);  mul_b = 17'sd209; end
            default: ;
         endcase
      end else if (cmd.op == OP_ROT) begin
         case (cmd.cnt)
            6'd0: begin mul_a = 27'(v_ff[ia]); mul_b = 17'(rc); end
            6'd1: begin mul_a = 27'(v_ff[ib]); mul_b = 17'(rs); end
            6'd2: begin mul_a = 27'(v_ff[ia]); mul_b = 17'(rs); end
            6'd3: begin mul_a = 27'(v_ff[ib]); mul_b = 17'(rc); end
            default: ;
         endcase
      end
   end

   // rotation rounding: (acc -/+ p + 8192) >>> 14
   logic signed [34:0] rsum;
   logic signed [34:0] rrnd;
   always_comb begin
      if (cmd.cnt == 6'd2) rsum = 35'(acc_ff) - 35'($signed(p_ff[33:0]));
      else                 rsum = 35'(acc_ff) + 35'($signed(p_ff[33:0]));
      rrnd = rsum + 35'sd8192;
   end

   // divider operands and result
   logic [26:0] cmag;
   logic [32:0] rmag;
   logic [27:0] trial;
   logic        ge;
   logic signed [35:0] qv;
   logic signed [35:0] cpos, rposn;

   assign cmag  = colnum_ff[26] ? 27'(-colnum_ff) : 27'(colnum_ff);
   assign rmag  = rownum_ff[33] ? 33'(-rownum_ff) : 33'(rownum_ff);
   assign trial = {rem_ff, quo_ff[33]};
   assign ge    = trial >= dd_ff;
   assign qv    = dneg_ff ? -36'(quo_ff) : 36'(quo_ff);
   assign cpos  = COL_MID + qv;
   assign rposn = ROW_MID - qv;

   // frame store: valid, depth, shade
   logic [20:0]   mem [DEPTH];
   logic [20:0]   rd_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] clr_ff;
   logic          hit_ff;
   logic [7:0]    pchar_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [20:0]   mem_wd;

   logic [9:0]  row_sel;
   logic [10:0] col_sel;
   logic [20:0] addr_full;
   logic        plot_ok, read_ok;

   assign row_sel   = kind_ff ? 10'(rrow_ff) : 10'(rowidx_ff);
   assign col_sel   = kind_ff ? 11'(rcol_ff) : 11'(colidx_ff);
   assign addr_full = 21'(row_sel) * 21'(COLS_L) + 21'(col_sel);
   assign plot_ok   = (den_ff > 20'sd0) && lit_ff && col_ok_ff && row_ok_ff;
   assign read_ok   = (10'(rrow_ff) < ROWS_L) && (11'(rcol_ff) < COLS_L);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = '0;
      if (cmd.op == OP_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
      end else if (cmd.op == OP_MWR && hit_ff) begin
         if (kind_ff) begin
            mem_we = 1'b1;
         end else if (!rd_ff[20] || ($signed(rd_ff[19:4]) > pz0_ff)) begin
            mem_we = 1'b1;
            mem_wd = {1'b1, pz0_ff, shade_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.op == OP_CLEAR && clr_ff != AW'(DEPTH - 1)) clr_ff <= clr_ff + 1'b1;
   end

   assign sts.clear_done = (cmd.op == OP_CLEAR) && (clr_ff == AW'(DEPTH - 1));

   // datapath registers
   logic [103:0] rsp_ff;

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
      if (cmd.load) begin
         kind_ff  <= req_tuser;
         v_ff[0]  <= req_tdata[15:0];
         v_ff[1]  <= req_tdata[31:16];
         v_ff[2]  <= req_tdata[47:32];
         v_ff[3]  <= req_tdata[63:48];
         v_ff[4]  <= req_tdata[79:64];
         v_ff[5]  <= req_tdata[95:80];
         pz0_ff   <= req_tdata[47:32];
         den_ff   <= 20'($signed(req_tdata[47:32])) + $signed({2'b00, depth_ofs_ff, 8'h00});
         lit_ff   <= in_nz[15] || (in_nz == 16'sd0);
         shade_ff <= (shade_raw > 7'd11) ? 4'd11 : shade_raw[3:0];
         rrow_ff  <= req_tdata[101:96];
         rcol_ff  <= req_tdata[109:102];
      end
      if (cmd.op == OP_MUL) begin
         case (cmd.cnt)
            6'd1: colnum_ff <= p_ff[26:0];
            6'd3: rownum_ff <= p_ff[33:0];
            6'd4: rowden_ff <= p_ff[27:0];
            default: ;
         endcase
      end
      if (cmd.op == OP_DIVC || cmd.op == OP_DIVR) begin
         if (cmd.cnt == 6'd0) begin
            rem_ff <= '0;
            if (cmd.op == OP_DIVC) begin
               quo_ff  <= 34'({cmag, 1'b0}) + 34'(den_ff[19:0]);
               dd_ff   <= 28'({den_ff[19:0], 1'b0});
               dneg_ff <= colnum_ff[26];
            end else begin
               quo_ff  <= {rmag, 1'b0} + 34'(rowden_ff[27:0]);
               dd_ff   <= {rowden_ff[26:0], 1'b0};
               dneg_ff <= rownum_ff[33];
            end
         end else if (cmd.cnt == DIV_LAST) begin
            if (cmd.op == OP_DIVC) begin
               colidx_ff <= cpos[CW-1:0];
               col_ok_ff <= (cpos >= 36'sd0) && (cpos < 36'(COLS));
            end else begin
               rowidx_ff <= rposn[RW-1:0];
               row_ok_ff <= (rposn >= 36'sd0) && (rposn < 36'(ROWS));
            end
         end else begin
            rem_ff <= ge ? 27'(trial - dd_ff) : trial[26:0];
            quo_ff <= {quo_ff[32:0], ge};
         end
      end
      if (cmd.op == OP_ROT) begin
         case (cmd.cnt)
            6'd1: acc_ff <= p_ff[33:0];
            6'd2: v_ff[ia] <= sat_rot(rrnd[34:14], rpos);
            6'd3: acc_ff <= p_ff[33:0];
            6'd4: v_ff[ib] <= sat_rot(rrnd[34:14], rpos);
            default: ;
         endcase
      end
      if (cmd.op == OP_ADDR) begin
         addr_ff <= addr_full[AW-1:0];
         hit_ff  <= kind_ff ? read_ok : plot_ok;
      end
      if (cmd.op == OP_MWR) begin
         if (!kind_ff)                pchar_ff <= 8'd0;
         else if (hit_ff && rd_ff[20]) pchar_ff <= shade_char(rd_ff[3:0]);
         else                         pchar_ff <= 8'd32;
      end
      if (cmd.out_load) begin
         if (kind_ff) rsp_ff <= {pchar_ff, 96'd0};
         else         rsp_ff <= {pchar_ff, v_ff[5], v_ff[4], v_ff[3],
                                 v_ff[2], v_ff[1], v_ff[0]};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== hw/rtl/zbuffer_point_renderer_top.sv =====
// throughput: one item at a time; plot time is set by the two 34-step restoring divides
// and the rotation sequence on the single shared multiplier
// reset: synchronous, active high; afterwards a clearing pass over all ROWS*COLS entries empties
// the frame store, during which no item is taken (configuration writes still land)
module zbuffer_point_renderer_top
   import zbpr_pkg::*;
#(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, read_row, read_col, zero pad
   input  logic [111:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rot_x, rot_y, rot_z, rot_normal_x, rot_normal_y, rot_normal_z, pixel_char
   output logic [103:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   zbpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   zbpr_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== sim/zbuffer_point_renderer_top_test.sv =====
module zbuffer_point_renderer_top_test
   import zbpr_pkg::*;
();

   localparam int NCOLS      = 218;
   localparam int NROWS      = 50;
   localparam int IDLE_LIMIT = 60000;
   localparam int PHASE_ITEMS = 90;
   localparam int KIND_PLOT  = 0;
   localparam int KIND_READ  = 1;
   localparam string SHADES  = ".,-~:;=!*#$@";

   typedef struct {
      bit          kind;
      logic [15:0] px, py, pz, nx, ny, nz;
      logic [5:0]  row;
      logic [7:0]  col;
      bit          fixed;
      logic [7:0]  ch;
   } item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_wen = 1'b0;
   logic [2:0]   csr_index = CSR_YAW_COS;
   logic [15:0]  csr_wdata = '0;

   // frame store and registers as the block should hold them
   bit          fs_valid [NROWS*NCOLS];
   logic [15:0] fs_depth [NROWS*NCOLS];
   logic [3:0]  fs_shade [NROWS*NCOLS];
   longint      csr_val  [8];

   logic [103:0] pending_results [$];
   int           lit_pixels [$];
   int           errors = 0;
   int           idle_cycles = 0;
   bit           quiet = 1'b0;
   int           stall_left = 0;

   zbuffer_point_renderer_top dut (.*);

   always #10 clock = ~clock;

   function automatic longint round_quot(longint n, longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (2 * m + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void rotate_pair(inout longint a, inout longint b, input longint c,
                                       input longint s, input longint lo, input longint hi);
      longint ra, rb;
      ra = clamp((a * c - b * s + 8192) >>> 14, lo, hi);
      rb = clamp((a * s + b * c + 8192) >>> 14, lo, hi);
      a = ra;
      b = rb;
   endfunction

   function automatic void rotate_vec(inout longint x, inout longint y, inout longint z,
                                      input longint lo, input longint hi);
      rotate_pair(x, z, csr_val[CSR_YAW_COS], csr_val[CSR_YAW_SIN], lo, hi);
      rotate_pair(x, y, csr_val[CSR_ROLL_COS], csr_val[CSR_ROLL_SIN], lo, hi);
      rotate_pair(y, z, csr_val[CSR_PITCH_COS], csr_val[CSR_PITCH_SIN], lo, hi);
   endfunction

   // updates the frame store and returns the response the item should give
   function automatic logic [103:0] render_item(item_type it);
      logic [103:0] r;
      longint px, py, pz, nx, ny, nz, den, lum, col, row, shade;
      int idx;
      r = '0;
      if (it.kind == KIND_READ) begin
         r[103:96] = 8'd32;
         if (it.row < NROWS && it.col < NCOLS) begin
            idx = it.row * NCOLS + it.col;
            if (fs_valid[idx]) r[103:96] = SHADES[fs_shade[idx]];
            fs_valid[idx] = 1'b0;
         end
         return r;
      end
      px = $signed(it.px); py = $signed(it.py); pz = $signed(it.pz);
      nx = $signed(it.nx); ny = $signed(it.ny); nz = $signed(it.nz);
      den = pz + csr_val[CSR_DEPTH_OFS] * 256;
      lum = -nz;
      if (den > 0 && lum >= 0) begin
         col = NCOLS / 2 + round_quot(px * csr_val[CSR_VIEW_DIST], den);
         row = NROWS / 2 - round_quot(py * csr_val[CSR_VIEW_DIST] * 100, den * 209);
         shade = (lum * 11) / 16384;
         if (shade > 11) shade = 11;
         if (col >= 0 && col < NCOLS && row >= 0 && row < NROWS) begin
            idx = int'(row * NCOLS + col);
            if (!fs_valid[idx] || $signed(fs_depth[idx]) > pz) begin
               fs_valid[idx] = 1'b1;
               fs_depth[idx] = it.pz;
               fs_shade[idx] = shade[3:0];
               lit_pixels.push_back(idx);
            end
         end
      end
      rotate_vec(px, py, pz, -32768, 32767);
      rotate_vec(nx, ny, nz, -16384, 16384);
      r[15:0]  = px[15:0];
      r[31:16] = py[15:0];
      r[47:32] = pz[15:0];
      r[63:48] = nx[15:0];
      r[79:64] = ny[15:0];
      r[95:80] = nz[15:0];
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(item_type it);
      logic [103:0] want;
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {2'b00, it.col, it.row, it.nz, it.ny, it.nx, it.pz, it.py, it.px};
      do @(posedge clock); while (!req_tready);
      want = render_item(it);
      if (it.fixed) want[103:96] = it.ch;
      pending_results.push_back(want);
   endtask

   task automatic write_regs(int phase);
      longint v;
      for (int i = 0; i < 8; i++) begin
         if (i < 6) begin
            case (phase)
               1: v = (i % 2) ? 16384 : -16384;
               2: v = (i % 2) ? -16384 : 16384;
               3: v = (i % 2) ? 16384 : 16384;
               default: v = longint'($urandom_range(0, 32768)) - 16384;
            endcase
         end else begin
            case (phase)
               1: v = (i == CSR_VIEW_DIST) ? 1023 : 1;
               2: v = (i == CSR_VIEW_DIST) ? 1 : 1023;
               4: v = (i == CSR_VIEW_DIST) ? 1023 : 0;
               default: v = $urandom_range(1, 1023);
            endcase
         end
         csr_wen   <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= v[15:0];
         @(posedge clock);
         csr_val[i] = (i < 6) ? longint'($signed(v[15:0])) : (v & 10'h3FF);
      end
      csr_wen <= 1'b0;
   endtask

   function automatic item_type random_item();
      item_type it;
      int idx;
      it.fixed = 0;
      it.ch = '0;
      it.px = 16'($urandom); it.py = 16'($urandom); it.pz = 16'($urandom);
      it.nx = 16'($urandom_range(0, 32768) - 16384);
      it.ny = 16'($urandom_range(0, 32768) - 16384);
      it.nz = 16'($urandom_range(0, 32768) - 16384);
      it.row = 6'($urandom); it.col = 8'($urandom);
      it.kind = ($urandom_range(0, 99) < 40) ? 1'(KIND_READ) : 1'(KIND_PLOT);
      if (it.kind == KIND_READ) begin
         if (lit_pixels.size() > 0 && $urandom_range(0, 1)) begin
            idx = lit_pixels[$urandom_range(0, lit_pixels.size() - 1)];
            it.row = 6'(idx / NCOLS);
            it.col = 8'(idx % NCOLS);
         end else if ($urandom_range(0, 3) != 0) begin
            it.row = 6'($urandom_range(0, NROWS - 1));
            it.col = 8'($urandom_range(0, NCOLS - 1));
         end
      end else begin
         // mostly lit points near the centre so that depth tests collide
         if ($urandom_range(0, 9) < 7) it.nz = 16'(-int'($urandom_range(0, 16384)));
         if ($urandom_range(0, 9) == 0) it.nz = 16'($urandom);
         if ($urandom_range(0, 9) == 0) it.nx = 16'($urandom);
         if ($urandom_range(0, 9) == 0) it.ny = 16'($urandom);
         if ($urandom_range(0, 2) != 0) begin
            it.px = 16'((int'($urandom_range(0, 8)) - 4) * 256);
            it.py = 16'((int'($urandom_range(0, 8)) - 4) * 256);
            it.pz = 16'((int'($urandom_range(0, 64)) - 32) * 256);
         end
      end
      return it;
   endfunction

   // receiver stalls, mostly short
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      logic [111:0] want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response transfer with none expected, got %h", $time, rsp_tdata);
         end else begin
            want = {8'h00, pending_results.pop_front()};
            got  = {8'h00, rsp_tdata};
            for (int k = 0; k < 7; k++)
               if (want[k*16 +: 16] !== got[k*16 +: 16]) begin
                  errors++;
                  $display("%0t: field %0d expected %h actual %h", $time, k,
                           want[k*16 +: 16], got[k*16 +: 16]);
               end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL zbuffer_point_renderer_top");
         $finish;
      end
   end

   initial begin
      item_type directed [] = '{
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd0, 8'd0, 1, 8'd32},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd63, 8'd255, 1, 8'd32},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd49, 8'd217, 1, 8'd32},
         '{KIND_PLOT, 0, 0, 0, 0, 0, 16'hC000, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd25, 8'd109, 1, "@"},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd25, 8'd109, 1, 8'd32},
         '{KIND_PLOT, 0, 0, 16'h0100, 0, 0, 16'hC000, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_PLOT, 0, 0, 0, 0, 0, 16'hE000, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_PLOT, 0, 0, 16'h0200, 0, 0, 16'hC000, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd25, 8'd109, 1, ";"},
         // overlong normal saturates to the brightest shade
         '{KIND_PLOT, 0, 0, 0, 0, 0, 16'h8000, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd25, 8'd109, 1, "@"},
         '{KIND_PLOT, 0, 0, 0, 0, 0, 16'h0001, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_READ, 0, 0, 0, 0, 0, 0, 6'd25, 8'd109, 1, 8'd32},
         '{KIND_PLOT, 16'h7FFF, 16'h8000, 16'h8000, 16'h4000, 16'hC000, 16'hC000,
           6'd0, 8'd0, 0, 8'd0},
         '{KIND_PLOT, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hC000, 16'h4000, 16'h0000,
           6'd0, 8'd0, 0, 8'd0},
         '{KIND_PLOT, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0, 8'd0, 0, 8'd0},
         '{KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           6'd25, 8'd109, 1, "."}
      };
      csr_val = '{16384, 0, 16384, 0, 16384, 0, 200, 270};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_item(directed[i]);
      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            repeat (20) @(posedge clock);
            write_regs(ph);
         end
         quiet = (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0)
         $display("PASS zbuffer_point_renderer_top");
      else
         $display("FAIL zbuffer_point_renderer_top");
      $finish;
   end

endmodule
